[rtl/core/nsvl_pkg.sv]
`timescale 1ns / 1ps
package nsvl_pkg;

  localparam int MaxSeedsDefault = 256;
  localparam int MapSize = 256;
  localparam int CoordW = 8;
  localparam int TypeW = 3;
  localparam int CharW = 7;
  localparam int SqW = 2 * CoordW;
  localparam int DistW = SqW + 1;
  localparam int LimW = 13;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_FLUSH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic [TypeW-1:0]  ty;
  } seed_t;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctl_t;

  typedef struct packed {
    logic             have;
    logic [TypeW-1:0] ty;
  } dist_res_t;

  function automatic logic [CharW-1:0] tile_char(input logic [TypeW-1:0] ty);
    logic [CharW-1:0] c;
    case (ty)
      3'd0:    c = 7'h6E;
      3'd1:    c = 7'h66;
      3'd2:    c = 7'h2E;
      3'd3:    c = 7'h5E;
      3'd4:    c = 7'h7E;
      3'd5:    c = 7'h2C;
      3'd6:    c = 7'h3D;
      default: c = 7'h00;
    endcase
    return c;
  endfunction

endpackage

[rtl/core/nsvl_cell.sv]
`timescale 1ns / 1ps
module nsvl_cell
  import nsvl_pkg::*;
(
  input  logic      clk,
  input  cell_ctl_t ctl,
  input  seed_t     prev_seed,
  input  seed_t     next_seed,
  output seed_t     seed
);

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      seed <= prev_seed;
    end else if (ctl.rotate) begin
      seed <= next_seed;
    end
  end

endmodule

[rtl/core/nsvl_dist.sv]
`timescale 1ns / 1ps
module nsvl_dist
  import nsvl_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              valid_in,
  input  seed_t             seed,
  input  logic [CoordW-1:0] qx,
  input  logic [CoordW-1:0] qy,
  output dist_res_t         res
);

  logic [CoordW-1:0] dx;
  logic [CoordW-1:0] dy;
  logic [SqW-1:0]    sqx;
  logic [SqW-1:0]    sqy;
  logic [TypeW-1:0]  s1_ty;
  logic              s1_valid;
  logic [DistW-1:0]  dsum;
  logic [DistW-1:0]  best;
  logic              hit;

  assign dx = (qx > seed.x) ? (qx - seed.x) : (seed.x - qx);
  assign dy = (qy > seed.y) ? (qy - seed.y) : (seed.y - qy);
  assign dsum = {1'b0, sqx} + {1'b0, sqy};

  // newest seed comes first, so a strict compare keeps it on ties
  assign hit = s1_valid && (!res.have || dsum < best);

  always_ff @(posedge clk) begin
    sqx   <= dx * dx;
    sqy   <= dy * dy;
    s1_ty <= seed.ty;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res.have <= 1'b0;
    end else if (start) begin
      res.have <= 1'b0;
    end else if (hit) begin
      res.have <= 1'b1;
    end
    if (hit) begin
      best   <= dsum;
      res.ty <= s1_ty;
    end
  end

endmodule

[rtl/core/nearest_seed_voronoi_labeler.sv]
`timescale 1ns / 1ps
// Nearest-seed Voronoi labeler.
// Input stream (s_*): each word is a clear, a seed load or a query, selected by
// s_tuser. Loads shift the seed into a ring of MAX_SEEDS cells, newest first;
// a clear empties the ring. Neither produces an output word.
// A query rotates the ring once through a single squared-distance unit, one
// seed per cycle, so it walks all MAX_SEEDS cells no matter how many seeds
// are stored; the ring length alone sets how long it runs. The result
// (type, character, found flag) lands in an output register and is offered on
// m_*. Input is taken only while no query is in progress; a result waiting
// for m_tready does not block loads or clears, but the next query holds its
// result until the previous word is taken.
// Reset empties the store and drops any pending result.
module nearest_seed_voronoi_labeler
  import nsvl_pkg::*;
#(
  parameter int MAX_SEEDS = MaxSeedsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // pos_x[7:0], pos_y[15:8], seed_type[18:16], zero pad
  input  logic [1:0]  s_tuser,   // op[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata    // terrain_type[2:0], terrain_char[9:3], found[10], zero pad
);

  localparam int CntW = $clog2(MAX_SEEDS + 1);
  localparam logic [CntW-1:0] NumCells = CntW'(MAX_SEEDS);
  localparam logic [CntW-1:0] LastStep = CntW'(MAX_SEEDS - 1);

  state_t state;
  state_t state_next;

  logic [CntW-1:0]   count;
  logic [CntW-1:0]   walk;
  logic [CoordW-1:0] qx;
  logic [CoordW-1:0] qy;
  logic              q_inside;

  logic              accept;
  op_t               op;
  seed_t             in_seed;
  logic              in_inside;
  cell_ctl_t         ctl;
  logic              start;
  logic              dist_valid;
  logic              out_load;
  dist_res_t         res;

  seed_t cells [MAX_SEEDS];

  logic [TypeW-1:0] out_type;
  logic [CharW-1:0] out_char;
  logic             out_found;

  assign op         = op_t'(s_tuser);
  assign in_seed.x  = s_tdata[7:0];
  assign in_seed.y  = s_tdata[15:8];
  assign in_seed.ty = s_tdata[18:16];
  assign in_inside  = ({{(LimW-CoordW){1'b0}}, in_seed.x} < LimW'(MapSize)) &&
                      ({{(LimW-CoordW){1'b0}}, in_seed.y} < LimW'(MapSize));
  assign accept     = s_tvalid && s_tready;

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept && op == OP_QUERY) begin
          state_next = S_WALK;
        end
      end
      S_WALK: begin
        if (walk == LastStep) begin
          state_next = S_FLUSH;
        end
      end
      S_FLUSH: begin
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    s_tready   = (state == S_IDLE);
    ctl.load   = accept && op == OP_LOAD && in_inside && count < NumCells;
    ctl.rotate = (state == S_WALK);
    start      = accept && op == OP_QUERY;
    dist_valid = (state == S_WALK) && q_inside && walk < count;
    out_load   = (state == S_DONE) && (!m_tvalid || m_tready);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
      walk  <= '0;
    end else begin
      state <= state_next;
      if (accept && op == OP_CLEAR) begin
        count <= '0;
      end else if (ctl.load) begin
        count <= count + 1'b1;
      end
      if (start) begin
        walk <= '0;
      end else if (state == S_WALK) begin
        walk <= walk + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qx       <= in_seed.x;
      qy       <= in_seed.y;
      q_inside <= in_inside;
    end
  end

  for (genvar i = 0; i < MAX_SEEDS; i++) begin : g_cell
    seed_t prev_seed;
    seed_t next_seed;
    if (i == 0) begin : g_head
      assign prev_seed = in_seed;
    end else begin : g_body
      assign prev_seed = cells[i-1];
    end
    if (i == MAX_SEEDS - 1) begin : g_tail
      assign next_seed = cells[0];
    end else begin : g_link
      assign next_seed = cells[i+1];
    end
    nsvl_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .prev_seed (prev_seed),
      .next_seed (next_seed),
      .seed      (cells[i])
    );
  end

  nsvl_dist u_dist (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .valid_in (dist_valid),
    .seed     (cells[0]),
    .qx       (qx),
    .qy       (qy),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_found <= res.have;
      out_type  <= res.have ? res.ty : '0;
      out_char  <= res.have ? tile_char(res.ty) : '0;
    end
  end

  assign m_tdata = {5'd0, out_found, out_char, out_type};

endmodule
